/* hw/rtl/spq_pkg.sv */
// Package with the shared constants, types and cell control struct of the priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Number of cells in the row, the entry width, and the count width that follows from the cells.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes on the mode input.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Control that the top level hands to every cell in a cycle.
  typedef struct packed {
    logic                     ins;      // Insert goes ahead this cycle.
    logic                     rem;      // Removal shifts the row down.
    logic                     occ;      // This cell holds a live entry.
    logic                     at_tail;  // This cell is the first free one.
    logic signed [DATA_W-1:0] value;    // Value being inserted.
  } cell_ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One cell of the sorted row: holds a single entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                             clk_i,
  input  spq_pkg::cell_ctrl_t              ctrl_i,
  input  logic                             left_ge_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_entry_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_entry_i,
  output logic                             ge_o,
  output logic signed [spq_pkg::DATA_W-1:0] entry_o
);

  logic signed [spq_pkg::DATA_W-1:0] entry_q, entry_d;

  // The new value belongs at or before this cell when it is not greater than the entry.
  assign ge_o = ctrl_i.occ && (ctrl_i.value <= entry_q);

  // On insert, cells from the insert point to the tail take the left entry or the new value.
  // On removal, every cell takes the entry of its right neighbor; the last cell keeps its own.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && (ge_o || ctrl_i.at_tail)) begin
      entry_d = left_ge_i ? left_entry_i : ctrl_i.value;
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: count, cell row and registered result.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         start_i while busy_o low   mode_i, value_i
//   result    out        done_o for one cycle       result_value_o, status_o, count_o
//
// The compare in all cells and the one-place shift happen
// together, so a new request may be given in every cycle and busy_o stays low.
// The result appears on the cycle after the request, with done_o high for that cycle.
// Reset clears the entry count and done_o only; the cell contents are read only below the count.
// The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              mode_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [spq_pkg::DATA_W-1:0] result_value_o,
  output logic [1:0]                        status_o,
  output logic [spq_pkg::CNT_W-1:0]         count_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                             accept;
  logic                             full, empty;
  logic                             do_ins, do_rem;
  logic [spq_pkg::CNT_W-1:0]        held_q, held_d;
  logic                             done_q;
  logic signed [spq_pkg::DATA_W-1:0] res_q, res_d;
  spq_pkg::status_e                 status_q, status_d;

  logic                             ge       [N];
  logic signed [spq_pkg::DATA_W-1:0] entry   [N];
  spq_pkg::cell_ctrl_t              ctrl     [N];

  // Requests are taken in every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign full   = (held_q == spq_pkg::CNT_W'(N));
  assign empty  = (held_q == '0);
  assign do_ins = accept && (mode_i == spq_pkg::MODE_INSERT) && !full;
  assign do_rem = accept && (mode_i == spq_pkg::MODE_REMOVE) && !empty;

  // Row of cells; each sees its neighbors' entries and the left neighbor's compare.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                              left_ge;
    logic signed [spq_pkg::DATA_W-1:0] left_entry, right_entry;

    assign ctrl[i].ins     = do_ins;
    assign ctrl[i].rem     = do_rem;
    assign ctrl[i].occ     = (spq_pkg::CNT_W'(i) < held_q);
    assign ctrl[i].at_tail = (spq_pkg::CNT_W'(i) == held_q);
    assign ctrl[i].value   = value_i;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_entry = value_i;
    end else begin : g_mid
      assign left_ge    = ge[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .left_ge_i    (left_ge),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .ge_o         (ge[i]),
      .entry_o      (entry[i])
    );
  end

  // Next count and the result of this request.
  always_comb begin
    held_d   = held_q;
    res_d    = '0;
    status_d = spq_pkg::ST_OK;
    if (mode_i == spq_pkg::MODE_INSERT) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        held_d = held_q + spq_pkg::CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_d    = '1;
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        res_d  = entry[0];
        held_d = held_q - spq_pkg::CNT_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        held_q <= held_d;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign count_o        = held_q;

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= spq_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // Every accepted request gives a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without result");

  // A full status comes with a count at capacity.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == spq_pkg::ST_FULL)) |-> (count_o == spq_pkg::CNT_W'(N)))
    else $error("full status with room left");

  // An empty removal returns minus one with a zero count.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == spq_pkg::ST_EMPTY)) |-> ((count_o == '0) && (result_value_o == -1)))
    else $error("empty status with wrong payload");

  // The two front entries stay in ascending order.
  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q >= spq_pkg::CNT_W'(2)) |-> (entry[0] <= entry[1]))
    else $error("front entries out of order");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the sorted priority queue: scoreboard class, drivers and monitor.
`timescale 1ns / 1ps

// One result as the queue should give it.
typedef struct {
  logic signed [spq_pkg::DATA_W-1:0] value;
  spq_pkg::status_e                  status;
  logic [spq_pkg::CNT_W-1:0]         count;
} queue_result_t;

// Keeps its own sorted copy of the queue and the results still owed by the block.
class QueueScoreboard;
  logic signed [spq_pkg::DATA_W-1:0] sorted_store [spq_pkg::CAPACITY];
  int unsigned                       held;
  queue_result_t                     owed_q [$];
  int unsigned                       mismatches;

  function new();
    held       = 0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  // Prints one line per mismatch and counts it.
  task report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Applies an accepted request to the copy and queues the result it causes.
  function void note_request(input logic mode, input logic signed [spq_pkg::DATA_W-1:0] value);
    queue_result_t r;
    int unsigned   pos;
    r.value  = '0;
    r.status = spq_pkg::ST_OK;
    if (mode == spq_pkg::MODE_INSERT) begin
      if (held >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // Walk down from the tail; the new value goes ahead of equal entries.
        pos = held;
        while (pos > 0 && value <= sorted_store[pos-1]) begin
          sorted_store[pos] = sorted_store[pos-1];
          pos--;
        end
        sorted_store[pos] = value;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.value  = -1;
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.value = sorted_store[0];
        for (int unsigned i = 1; i < held; i++) sorted_store[i-1] = sorted_store[i];
        held--;
      end
    end
    r.count = held[spq_pkg::CNT_W-1:0];
    owed_q.push_back(r);
  endfunction

  // Compares one result with the oldest one owed.
  task check_result(input logic signed [spq_pkg::DATA_W-1:0] value, input logic [1:0] status,
                    input logic [spq_pkg::CNT_W-1:0] count);
    queue_result_t r;
    if (owed_q.size() == 0) begin
      report($sformatf("result %0d/%0d/%0d with no request pending", value, status, count));
    end else begin
      r = owed_q.pop_front();
      if (value !== r.value)
        report($sformatf("result_value %0d, expected %0d", value, r.value));
      if (status !== r.status)
        report($sformatf("status %0d, expected %0d", status, r.status));
      if (count !== r.count)
        report($sformatf("count %0d, expected %0d", count, r.count));
    end
  endtask
endclass

module testbench;
  localparam int unsigned STALL_LIMIT = 1000;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start_i;
  logic                              mode_i;
  logic signed [spq_pkg::DATA_W-1:0] value_i;
  logic                              busy_o;
  logic                              done_o;
  logic signed [spq_pkg::DATA_W-1:0] result_value_o;
  logic [1:0]                        status_o;
  logic [spq_pkg::CNT_W-1:0]         count_o;

  QueueScoreboard sb = new();
  int unsigned    stall_cycles = 0;

  sorted_priority_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Note accepted requests and check results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(mode_i, value_i);
      if (done_o) sb.check_result(result_value_o, status_o, count_o);
    end
  end

  // Watchdog on cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one request from a falling edge and holds it until accepted.
  task automatic send_request(input logic mode, input logic signed [spq_pkg::DATA_W-1:0] value);
    start_i <= 1'b1;
    mode_i  <= mode;
    value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves the request lines idle with junk payload for a number of cycles.
  task automatic idle_sender(input int unsigned cycles);
    start_i <= 1'b0;
    mode_i  <= 1'($urandom);
    value_i <= $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Holds off until every owed result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Random values: many near zero for duplicates, some extremes, the rest anything.
  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 8)) - 32'sd4;
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [spq_pkg::DATA_W-1:0] fill_values [16] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5, -32'sd5,
      32'sh7FFF_FFFE, 32'sh8000_0001, 32'sd5, 32'sd0, 32'sh5555_5555, 32'shAAAA_AAAA,
      -32'sd1, 32'sd3
    };
    int unsigned insert_pct;
    int unsigned idle_pct;

    rst_ni  = 1'b0;
    start_i = 1'b0;
    mode_i  = spq_pkg::MODE_INSERT;
    value_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: removal from empty, fill with extremes and duplicates, inserts when full, then removals.
    send_request(spq_pkg::MODE_REMOVE, 32'sd7);
    foreach (fill_values[i]) send_request(spq_pkg::MODE_INSERT, fill_values[i]);
    send_request(spq_pkg::MODE_INSERT, 32'sd42);
    send_request(spq_pkg::MODE_INSERT, 32'sh8000_0000);
    repeat (4) send_request(spq_pkg::MODE_REMOVE, $urandom);
    drain_results();

    // Random: phases lean toward filling, draining or a mix, with idle bursts.
    insert_pct = 50;
    idle_pct   = 0;
    for (int i = 0; i < 830; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 4))
          0: insert_pct = 85;
          1: insert_pct = 15;
          2: insert_pct = 50;
          3: insert_pct = 65;
          default: insert_pct = 35;
        endcase
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end
      if (i == 300 || i == 600) drain_results();
      if (i < 680 && $urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 18));
      if ($urandom_range(0, 99) < insert_pct) send_request(spq_pkg::MODE_INSERT, pick_value());
      else send_request(spq_pkg::MODE_REMOVE, $urandom);
    end

    // Wait for the last results, then wait a little longer for stray strobes.
    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
bench/testbench.sv
